FILE: rtl/core/hsl2rgb_pkg.sv
// Shared constants and types for the HSL to RGB converter.
`default_nettype none

package hsl2rgb_pkg;

  // Field widths
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned LEVEL_W = 13;
  localparam int unsigned CHAN_W  = 8;

  // Default level format
  localparam int unsigned LEVEL_FRAC_BITS_DEF = 12;

  // Hue in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_MAX         = 15'd23039;
  localparam logic [12:0]      HUE_SECTOR      = 13'd3840;
  localparam logic [12:0]      HUE_TWO_SECTORS = 13'd7680;
  localparam logic [HUE_W-1:0] HUE_FOUR_SECTORS = 15'd15360;
  localparam int unsigned      HUE_W_BITS      = 12;  // width of the 0..3840 ramp

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  // Register stages in the datapath
  localparam int unsigned STAGES = 5;

  // 60-degree sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic [STAGES-1:0] load;   // stage register takes new contents
    logic [STAGES-1:0] valid;  // stage holds a live word
  } pipe_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/hsl2rgb_intf.sv
// Valid/ready channel interfaces for HSL input and RGB output words.
`default_nettype none

interface hsl2rgb_hsl_if;
  logic                              valid;
  logic                              ready;
  logic [hsl2rgb_pkg::HUE_W-1:0]     hue;
  logic [hsl2rgb_pkg::LEVEL_W-1:0]   saturation;
  logic [hsl2rgb_pkg::LEVEL_W-1:0]   lightness;

  modport source (output valid, hue, saturation, lightness, input ready);
  modport sink   (input valid, hue, saturation, lightness, output ready);
endinterface

interface hsl2rgb_rgb_if;
  logic                             valid;
  logic                             ready;
  logic [hsl2rgb_pkg::CHAN_W-1:0]   red;
  logic [hsl2rgb_pkg::CHAN_W-1:0]   green;
  logic [hsl2rgb_pkg::CHAN_W-1:0]   blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hsl2rgb_pipe_ctrl.sv
// Valid bits and per-stage load enables for the conversion pipeline.
`default_nettype none

module hsl2rgb_pipe_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic                    out_ready_i,
  output      logic                    out_valid_o,
  output      hsl2rgb_pkg::pipe_ctrl_t ctrl_o
);

  localparam int unsigned N = hsl2rgb_pkg::STAGES;

  logic [N-1:0] valid_q, valid_d;
  logic [N:0]   rdy;
  logic [N-1:0] load;

  // A stage may load when it is empty or its contents move on.
  always_comb begin
    rdy[N] = out_ready_i;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    load = rdy[N-1:0];
    valid_d = valid_q;
    for (int k = 0; k < N; k++) begin
      if (load[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o   = rdy[0];
  assign out_valid_o  = valid_q[N-1];
  assign ctrl_o.load  = load;
  assign ctrl_o.valid = valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsl2rgb_front.sv
// Stage 0: input clamping, sector decode, hue ramp and lightness distance.
`default_nettype none

module hsl2rgb_front #(
  parameter int unsigned LEVEL_FRAC_BITS = hsl2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 load_i,
  input  wire logic [hsl2rgb_pkg::HUE_W-1:0]        hue_i,
  input  wire logic [hsl2rgb_pkg::LEVEL_W-1:0]      saturation_i,
  input  wire logic [hsl2rgb_pkg::LEVEL_W-1:0]      lightness_i,
  output      hsl2rgb_pkg::sector_e                 sector_o,
  output      logic [hsl2rgb_pkg::HUE_W_BITS-1:0]   ramp_o,
  output      logic [LEVEL_FRAC_BITS:0]             sat_o,
  output      logic [LEVEL_FRAC_BITS:0]             lit_o,
  output      logic [LEVEL_FRAC_BITS:0]             omd_o
);

  localparam int unsigned LW = LEVEL_FRAC_BITS + 1;
  localparam int unsigned CW = (LW > hsl2rgb_pkg::LEVEL_W) ? LW : hsl2rgb_pkg::LEVEL_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << LEVEL_FRAC_BITS;
  localparam logic [LW:0]   ONE_T = (LW + 1)'(1) << LEVEL_FRAC_BITS;

  logic [CW-1:0]                      sat_x, lit_x;
  logic [LW-1:0]                      sat_c, lit_c;
  logic [LW:0]                        twol, lvl_gap, omd_t;
  logic [hsl2rgb_pkg::HUE_W-1:0]      hue_c, hue_off;
  logic [1:0]                         pair;
  logic [12:0]                        hm, ramp_t;
  logic                               upper;
  logic [2:0]                         sec;

  hsl2rgb_pkg::sector_e               sector_q;
  logic [hsl2rgb_pkg::HUE_W_BITS-1:0] ramp_q;
  logic [LW-1:0]                      sat_q, lit_q, omd_q;

  always_comb begin
    sat_x = CW'(saturation_i);
    lit_x = CW'(lightness_i);
    sat_c = LW'((sat_x > ONE_C) ? ONE_C : sat_x);
    lit_c = LW'((lit_x > ONE_C) ? ONE_C : lit_x);

    twol    = {lit_c, 1'b0};
    lvl_gap = (twol >= ONE_T) ? (twol - ONE_T) : (ONE_T - twol);
    omd_t   = ONE_T - lvl_gap;

    hue_c = (hue_i > hsl2rgb_pkg::HUE_MAX) ? hsl2rgb_pkg::HUE_MAX : hue_i;
    // hue mod 7680 from the 120-degree pair index
    if (hue_c >= hsl2rgb_pkg::HUE_FOUR_SECTORS) begin
      pair    = 2'd2;
      hue_off = hsl2rgb_pkg::HUE_FOUR_SECTORS;
    end else if (hue_c >= hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_TWO_SECTORS)) begin
      pair    = 2'd1;
      hue_off = hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::HUE_TWO_SECTORS);
    end else begin
      pair    = 2'd0;
      hue_off = '0;
    end
    hm     = 13'(hue_c - hue_off);
    upper  = (hm >= hsl2rgb_pkg::HUE_SECTOR);
    // 3840 - |hm - 3840|
    ramp_t = upper ? (hsl2rgb_pkg::HUE_TWO_SECTORS - hm) : hm;
    sec    = {pair, 1'b0} + {2'b00, upper};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sector_q <= hsl2rgb_pkg::sector_e'(sec);
      ramp_q   <= ramp_t[hsl2rgb_pkg::HUE_W_BITS-1:0];
      sat_q    <= sat_c;
      lit_q    <= lit_c;
      omd_q    <= omd_t[LW-1:0];
    end
  end

  assign sector_o = sector_q;
  assign ramp_o   = ramp_q;
  assign sat_o    = sat_q;
  assign lit_o    = lit_q;
  assign omd_o    = omd_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsl2rgb_chroma.sv
// Stages 1-2: chroma product, then chroma times hue ramp and the offset m.
`default_nettype none

module hsl2rgb_chroma #(
  parameter int unsigned LEVEL_FRAC_BITS = hsl2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                                  clk_i,
  input  wire logic                                                  load1_i,
  input  wire logic                                                  load2_i,
  input  wire hsl2rgb_pkg::sector_e                                  sector_i,
  input  wire logic [hsl2rgb_pkg::HUE_W_BITS-1:0]                    ramp_i,
  input  wire logic [LEVEL_FRAC_BITS:0]                              sat_i,
  input  wire logic [LEVEL_FRAC_BITS:0]                              lit_i,
  input  wire logic [LEVEL_FRAC_BITS:0]                              omd_i,
  output      hsl2rgb_pkg::sector_e                                  sector_o,
  output      logic [LEVEL_FRAC_BITS+hsl2rgb_pkg::HUE_W_BITS:0]      xprod_o,
  output      logic [LEVEL_FRAC_BITS:0]                              chroma_o,
  output      logic [LEVEL_FRAC_BITS:0]                              offset_o
);

  localparam int unsigned LW  = LEVEL_FRAC_BITS + 1;
  localparam int unsigned XPW = LW + hsl2rgb_pkg::HUE_W_BITS;

  logic [2*LW-1:0]                    cprod;
  logic [XPW-1:0]                     xprod;
  logic [LW-1:0]                      half, offs;

  hsl2rgb_pkg::sector_e               sector1_q, sector2_q;
  logic [hsl2rgb_pkg::HUE_W_BITS-1:0] ramp1_q;
  logic [LW-1:0]                      c1_q, lit1_q, c2_q, m2_q;
  logic [XPW-1:0]                     xp2_q;

  // c = (1 - |2l - 1|) * s, truncated
  assign cprod = omd_i * sat_i;

  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      sector1_q <= sector_i;
      ramp1_q   <= ramp_i;
      c1_q      <= cprod[LEVEL_FRAC_BITS +: LW];
      lit1_q    <= lit_i;
    end
  end

  always_comb begin
    xprod = XPW'(c1_q) * XPW'(ramp1_q);
    half  = c1_q >> 1;
    offs  = (lit1_q >= half) ? (lit1_q - half) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      sector2_q <= sector1_q;
      xp2_q     <= xprod;
      c2_q      <= c1_q;
      m2_q      <= offs;
    end
  end

  assign sector_o = sector2_q;
  assign xprod_o  = xp2_q;
  assign chroma_o = c2_q;
  assign offset_o = m2_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsl2rgb_mix.sv
// Stages 3-4: divide by one sector width, then channel placement and scaling.
`default_nettype none

module hsl2rgb_mix #(
  parameter int unsigned LEVEL_FRAC_BITS = hsl2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              load3_i,
  input  wire logic                                              load4_i,
  input  wire hsl2rgb_pkg::sector_e                              sector_i,
  input  wire logic [LEVEL_FRAC_BITS+hsl2rgb_pkg::HUE_W_BITS:0]  xprod_i,
  input  wire logic [LEVEL_FRAC_BITS:0]                          chroma_i,
  input  wire logic [LEVEL_FRAC_BITS:0]                          offset_i,
  output      logic [hsl2rgb_pkg::CHAN_W-1:0]                    red_o,
  output      logic [hsl2rgb_pkg::CHAN_W-1:0]                    green_o,
  output      logic [hsl2rgb_pkg::CHAN_W-1:0]                    blue_o
);

  localparam int unsigned LW  = LEVEL_FRAC_BITS + 1;
  localparam int unsigned XPW = LW + hsl2rgb_pkg::HUE_W_BITS;
  // 3840 = 256 * 15: drop 8 bits, then multiply by a reciprocal of 15
  localparam int unsigned QW  = XPW - 8;
  localparam int unsigned SH  = QW + 4;
  localparam int unsigned KW  = QW + 1;
  localparam logic [KW-1:0] RECIP15 = KW'(((64'd1 << SH) + 64'd14) / 64'd15);
  localparam int unsigned SW  = LW + 1;
  localparam int unsigned PW  = SW + 8;
  localparam int unsigned VW  = PW - LEVEL_FRAC_BITS;

  logic [QW-1:0]        qv;
  logic [QW+KW-1:0]     qprod;

  hsl2rgb_pkg::sector_e sector3_q;
  logic [LW-1:0]        x3_q, c3_q, m3_q;
  logic [LW-1:0]        r_l, g_l, b_l;
  logic [hsl2rgb_pkg::CHAN_W-1:0] red_q, green_q, blue_q;
  logic [hsl2rgb_pkg::CHAN_W-1:0] red_d, green_d, blue_d;

  // (level + m) * 255 >> frac, saturated
  function automatic logic [hsl2rgb_pkg::CHAN_W-1:0] to_byte(
    input logic [LW-1:0] chan,
    input logic [LW-1:0] offs
  );
    logic [SW-1:0] s;
    logic [PW-1:0] p;
    logic [VW-1:0] v;
    s = SW'(chan) + SW'(offs);
    p = {s, 8'd0} - PW'(s);
    v = p[PW-1:LEVEL_FRAC_BITS];
    to_byte = (v > VW'(hsl2rgb_pkg::CHAN_MAX)) ? hsl2rgb_pkg::CHAN_MAX
                                               : v[hsl2rgb_pkg::CHAN_W-1:0];
  endfunction

  assign qv    = xprod_i[XPW-1:8];
  assign qprod = qv * RECIP15;

  always_ff @(posedge clk_i) begin
    if (load3_i) begin
      sector3_q <= sector_i;
      x3_q      <= qprod[SH +: LW];
      c3_q      <= chroma_i;
      m3_q      <= offset_i;
    end
  end

  always_comb begin
    unique case (sector3_q)
      hsl2rgb_pkg::SEC_RED_YEL: begin r_l = c3_q; g_l = x3_q; b_l = '0;   end
      hsl2rgb_pkg::SEC_YEL_GRN: begin r_l = x3_q; g_l = c3_q; b_l = '0;   end
      hsl2rgb_pkg::SEC_GRN_CYN: begin r_l = '0;   g_l = c3_q; b_l = x3_q; end
      hsl2rgb_pkg::SEC_CYN_BLU: begin r_l = '0;   g_l = x3_q; b_l = c3_q; end
      hsl2rgb_pkg::SEC_BLU_MAG: begin r_l = x3_q; g_l = '0;   b_l = c3_q; end
      default:                  begin r_l = c3_q; g_l = '0;   b_l = x3_q; end
    endcase
    red_d   = to_byte(r_l, m3_q);
    green_d = to_byte(g_l, m3_q);
    blue_d  = to_byte(b_l, m3_q);
  end

  always_ff @(posedge clk_i) begin
    if (load4_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

FILE: rtl/core/hsl_to_rgb_converter_unit.sv
// Top level of the HSL to RGB converter: five-stage valid/ready pipeline.
`default_nettype none

// HSL to 8-bit RGB color converter. Each word on hsl_i (hue in 1/64 degree,
// saturation and lightness with LEVEL_FRAC_BITS fractional bits) yields one
// word on rgb_o, in order. Hue above 23039 is clamped to 23039, levels above
// 1.0 are clamped to 1.0. Math: c = (1-|2l-1|)*s, x = c*ramp/3840 with
// ramp = 3840-|hue mod 7680 - 3840|, m = l - c/2, sector select, then each
// channel is floor((chan+m)*255), all truncated. Throughput is one word per
// clock while rgb_o is not stalled; rgb_o.valid rises once the word has
// passed all five register stages. The five register stages are: input
// clamp and sector decode,
// chroma multiply, chroma-times-ramp multiply, reciprocal multiply for the
// divide by 3840, channel mix into the output register. Each stage holds its
// word while the stage after it is full and stalled, so bubbles are squeezed
// out and hsl_i.ready drops only once every stage holds a live word. No state
// survives between words; reset only clears the valid bits.
module hsl_to_rgb_converter_unit #(
  parameter int unsigned LEVEL_FRAC_BITS = hsl2rgb_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  hsl2rgb_hsl_if.sink   hsl_i,
  hsl2rgb_rgb_if.source rgb_o
);

  localparam int unsigned LW  = LEVEL_FRAC_BITS + 1;
  localparam int unsigned XPW = LW + hsl2rgb_pkg::HUE_W_BITS;

  hsl2rgb_pkg::pipe_ctrl_t ctrl;

  hsl2rgb_pkg::sector_e               sector0, sector2;
  logic [hsl2rgb_pkg::HUE_W_BITS-1:0] ramp0;
  logic [LW-1:0]                      sat0, lit0, omd0;
  logic [XPW-1:0]                     xprod2;
  logic [LW-1:0]                      chroma2, offset2;

  // Valid bits and load enables for all stages
  hsl2rgb_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsl_i.valid),
    .in_ready_o  (hsl_i.ready),
    .out_ready_i (rgb_o.ready),
    .out_valid_o (rgb_o.valid),
    .ctrl_o      (ctrl)
  );

  // Stage 0: clamp, hue sector and ramp, 1-|2l-1|
  hsl2rgb_front #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .load_i       (ctrl.load[0]),
    .hue_i        (hsl_i.hue),
    .saturation_i (hsl_i.saturation),
    .lightness_i  (hsl_i.lightness),
    .sector_o     (sector0),
    .ramp_o       (ramp0),
    .sat_o        (sat0),
    .lit_o        (lit0),
    .omd_o        (omd0)
  );

  // Stages 1-2: chroma, chroma*ramp, offset m
  hsl2rgb_chroma #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_chroma (
    .clk_i    (clk_i),
    .load1_i  (ctrl.load[1]),
    .load2_i  (ctrl.load[2]),
    .sector_i (sector0),
    .ramp_i   (ramp0),
    .sat_i    (sat0),
    .lit_i    (lit0),
    .omd_i    (omd0),
    .sector_o (sector2),
    .xprod_o  (xprod2),
    .chroma_o (chroma2),
    .offset_o (offset2)
  );

  // Stages 3-4: x = c*ramp/3840, placement, scaling to bytes
  hsl2rgb_mix #(
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
  ) u_mix (
    .clk_i    (clk_i),
    .load3_i  (ctrl.load[3]),
    .load4_i  (ctrl.load[4]),
    .sector_i (sector2),
    .xprod_i  (xprod2),
    .chroma_i (chroma2),
    .offset_i (offset2),
    .red_o    (rgb_o.red),
    .green_o  (rgb_o.green),
    .blue_o   (rgb_o.blue)
  );

`ifndef NO_ASSERTIONS
  // An empty pipeline always takes a word.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.valid == '0) |-> hsl_i.ready)
    else $error("pipeline empty but input not ready");

  // With rgb_o.ready held high, an accepted word reaches rgb_o.valid.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(hsl_i.valid && hsl_i.ready, 4) && $past(rst_ni, 5) &&
     $past(rgb_o.ready, 3) && $past(rgb_o.ready, 2) &&
     $past(rgb_o.ready, 1) && rgb_o.ready) |=> rgb_o.valid)
    else $error("accepted word did not reach output in time");
`endif

endmodule

`default_nettype wire
